@@ sv/ndpr_pkg.sv @@
`timescale 1ns / 1ps

package ndpr_pkg;

    localparam int MAX_ATOMS = 64;
    localparam int IDX_W     = $clog2(MAX_ATOMS);
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
    localparam int COORD_W   = 24;
    localparam int OCC_W     = 16;
    localparam int ATOM_W    = 3 * COORD_W + OCC_W;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = 50;
    localparam int OIDX_W    = 6;
    localparam int OUT_W     = 8;
    localparam int STEP_W    = 3;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(4);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_LAT_I,
        ST_RD_J,
        ST_LAT_J,
        ST_CALC,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    function automatic logic [COORD_W-1:0] f_abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
        return m[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] f_coord(
        input logic [ATOM_W-1:0] atom,
        input t_axis             ax
    );
        logic [COORD_W-1:0] c;
        case (ax)
            AX_X:    c = atom[0 +: COORD_W];
            AX_Y:    c = atom[COORD_W +: COORD_W];
            AX_Z:    c = atom[2*COORD_W +: COORD_W];
            default: c = atom[0 +: COORD_W];
        endcase
        return c;
    endfunction

endpackage

@@ sv/near_duplicate_point_removal.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit first)                         Handshake
// s_axis    in   tdata: pos_x, pos_y, pos_z, occupancy; tlast     tvalid/tready
// m_axis    out  tdata: atom_index, kept, zero pad; tlast         tvalid/tready
// cfg       in   i_cfg_wr_data: min_dist_squared                  i_cfg_wr_en
//
// Load: one atom per cycle while tvalid is high. The set ends on tlast or when the store is full.
// Scan: each live outer atom is compared with each later live atom, and its pass ends if it
// is removed; removed atoms are skipped. One read port and one 24x24 multiplier.
// Output: one atom per cycle while tready is high, n atoms in load order; tready low stalls it.
// Reset clears control state, removal flags and the threshold; the atom
// memory is not cleared. s_axis_tready is high only while loading.

module near_duplicate_point_removal
    import ndpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [ATOM_W-1:0]   s_axis_tdata,  // pos_x, pos_y, pos_z, occupancy
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,  // atom_index, kept, zero pad
    output logic                m_axis_tlast,
    input  logic                i_cfg_wr_en,
    input  logic [DIST_W-1:0]   i_cfg_wr_data
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_i, n_i;
    logic [CNT_W-1:0]      r_j, n_j;
    logic [CNT_W-1:0]      r_k, n_k;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [MAX_ATOMS-1:0]  r_removed, n_removed;
    logic [DIST_W-1:0]     r_min_dist;
    logic [ATOM_W-1:0]     r_a, n_a;
    logic [COORD_W-1:0]    r_diff, n_diff;
    logic [SQ_W-1:0]       r_prod, n_prod;
    logic [DIST_W-1:0]     r_acc, n_acc;
    logic [ATOM_W-1:0]     r_atom_mem [MAX_ATOMS];
    logic [ATOM_W-1:0]     r_rd_data;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_set_end;
    logic                  w_out_last;
    logic                  w_close;
    logic                  w_i_lower;
    logic                  w_rd_en;
    logic [IDX_W-1:0]      w_rd_addr;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_acc  = m_axis_tvalid && m_axis_tready;
    assign w_set_end  = s_axis_tlast || (r_count == CNT_W'(MAX_ATOMS - 1));
    assign w_out_last = (r_k == r_count - CNT_W'(1));
    assign w_close    = (r_acc < r_min_dist);
    assign w_i_lower  = (r_a[ATOM_W-1 -: OCC_W] < r_rd_data[ATOM_W-1 -: OCC_W]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && w_set_end) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                if (r_i == r_count) begin
                    n_state = ST_OUT;
                end else if (!r_removed[r_i[IDX_W-1:0]]) begin
                    n_state = ST_LAT_I;
                end
            end
            ST_LAT_I: n_state = ST_RD_J;
            ST_RD_J: begin
                if (r_j == r_count) begin
                    n_state = ST_RD_I;
                end else if (!r_removed[r_j[IDX_W-1:0]]) begin
                    n_state = ST_LAT_J;
                end
            end
            ST_LAT_J: n_state = ST_CALC;
            ST_CALC: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = (w_close && w_i_lower) ? ST_RD_I : ST_RD_J;
            end
            ST_OUT: begin
                if (w_out_acc && w_out_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_axis_tready = (r_state == ST_LOAD);
        m_axis_tvalid = (r_state == ST_OUT);
        m_axis_tdata  = {{(OUT_W - OIDX_W - 1){1'b0}},
                         !r_removed[r_k[IDX_W-1:0]], OIDX_W'(r_k)};
        m_axis_tlast  = w_out_last;
        w_rd_en       = (r_state == ST_RD_I) || (r_state == ST_RD_J);
        w_rd_addr     = (r_state == ST_RD_J) ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];

        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_step    = r_step;
        n_removed = r_removed;
        n_a       = r_a;
        n_diff    = r_diff;
        n_prod    = r_prod;
        n_acc     = r_acc;

        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    n_count = r_count + CNT_W'(1);
                    n_i     = '0;
                end
            end
            ST_RD_I: begin
                if (r_i == r_count) begin
                    n_k = '0;
                end else if (r_removed[r_i[IDX_W-1:0]]) begin
                    n_i = r_i + CNT_W'(1);
                end
            end
            ST_LAT_I: begin
                n_a = r_rd_data;
                n_j = r_i + CNT_W'(1);
            end
            ST_RD_J: begin
                if (r_j == r_count) begin
                    n_i = r_i + CNT_W'(1);
                end else if (r_removed[r_j[IDX_W-1:0]]) begin
                    n_j = r_j + CNT_W'(1);
                end
            end
            ST_LAT_J: begin
                n_step = '0;
                n_acc  = '0;
            end
            ST_CALC: begin
                // difference, square and sum overlap by one axis each
                n_step = r_step + STEP_W'(1);
                if (r_step < STEP_W'(3)) begin
                    n_diff = f_abs_diff(f_coord(r_a, t_axis'(r_step[1:0])),
                                        f_coord(r_rd_data, t_axis'(r_step[1:0])));
                end
                if (r_step >= STEP_W'(1) && r_step <= STEP_W'(3)) begin
                    n_prod = r_diff * r_diff;
                end
                if (r_step >= STEP_W'(2)) begin
                    n_acc = r_acc + DIST_W'(r_prod);
                end
            end
            ST_CMP: begin
                if (w_close && w_i_lower) begin
                    n_removed[r_i[IDX_W-1:0]] = 1'b1;
                    n_i = r_i + CNT_W'(1);
                end else begin
                    if (w_close) begin
                        n_removed[r_j[IDX_W-1:0]] = 1'b1;
                    end
                    n_j = r_j + CNT_W'(1);
                end
            end
            ST_OUT: begin
                if (w_out_acc) begin
                    n_k = r_k + CNT_W'(1);
                    if (w_out_last) begin
                        n_count   = '0;
                        n_removed = '0;
                    end
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_step     <= '0;
            r_removed  <= '0;
            r_min_dist <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_step    <= n_step;
            r_removed <= n_removed;
            if (i_cfg_wr_en) begin
                r_min_dist <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_diff <= n_diff;
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_atom_mem[r_count[IDX_W-1:0]] <= s_axis_tdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_atom_mem[w_rd_addr];
        end
    end

`ifndef NO_ASSERTIONS
    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("load and output active together");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ATOMS))
        else $error("atom count beyond store depth");

    a_out_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_k < r_count))
        else $error("result index outside set");

    a_pair_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |->
            (!r_removed[r_i[IDX_W-1:0]] && !r_removed[r_j[IDX_W-1:0]] && r_i < r_j))
        else $error("compared pair not live");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_out_last) |=> (r_count == '0 && r_removed == '0))
        else $error("set state not cleared after last result");
`endif

endmodule

@@ test/near_duplicate_point_removal_test.sv @@
`timescale 1ns / 1ps

module near_duplicate_point_removal_test;
    import ndpr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [OCC_W-1:0]   occ;
    } t_atom;

    typedef struct packed {
        logic [OIDX_W-1:0] atom_index;
        logic              kept;
        logic              last_result;
    } t_verdict;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [ATOM_W-1:0] s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;
    logic              i_cfg_wr_en;
    logic [DIST_W-1:0] i_cfg_wr_data;

    logic [DIST_W-1:0] dist_limit;
    t_atom             set_atoms [MAX_ATOMS];
    int                set_size;
    t_verdict          pending_verdicts [$];
    t_verdict          due;
    int                error_count;
    int                cycle_count;
    int                sender_idle_pct;
    int                sink_stall_pct;

    near_duplicate_point_removal dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("near_duplicate_point_removal_test: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic longint pair_dist_sq(t_atom a, t_atom b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        dz = longint'($signed(a.z)) - longint'($signed(b.z));
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Resolve the finished set and queue one verdict per atom in load order.
    function automatic void cull_duplicates();
        bit       gone [MAX_ATOMS];
        t_verdict v;
        foreach (gone[k]) gone[k] = 1'b0;
        for (int i = 0; i < set_size; i++) begin
            if (gone[i]) continue;
            for (int j = i + 1; j < set_size; j++) begin
                if (gone[j]) continue;
                if (pair_dist_sq(set_atoms[i], set_atoms[j]) < longint'(dist_limit)) begin
                    if (set_atoms[i].occ < set_atoms[j].occ) begin
                        gone[i] = 1'b1;
                        break;
                    end
                    gone[j] = 1'b1;
                end
            end
        end
        for (int k = 0; k < set_size; k++) begin
            v.atom_index  = OIDX_W'(k);
            v.kept        = !gone[k];
            v.last_result = (k == set_size - 1);
            pending_verdicts.insert(pending_verdicts.size(), v);
        end
        set_size = 0;
    endfunction

    function automatic void record_atom(t_atom a, logic is_last);
        set_atoms[set_size] = a;
        set_size++;
        if (is_last || set_size == MAX_ATOMS) cull_duplicates();
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: atom_index %0d", m_axis_tdata[OIDX_W-1:0]);
                error_count++;
            end else begin
                due = pending_verdicts.pop_front();
                if (m_axis_tdata[OIDX_W-1:0] !== due.atom_index) begin
                    $error("atom_index: expected %0d, got %0d",
                           due.atom_index, m_axis_tdata[OIDX_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[OIDX_W] !== due.kept) begin
                    $error("kept: expected %0b, got %0b", due.kept, m_axis_tdata[OIDX_W]);
                    error_count++;
                end
                if (m_axis_tlast !== due.last_result) begin
                    $error("last_result: expected %0b, got %0b", due.last_result, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    task automatic send_atom(t_atom a, logic is_last);
        @(negedge i_clk);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a.occ, a.z, a.y, a.x};
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        record_atom(a, is_last);
    endtask

    // Drop valid, then hold until every queued verdict is out and the block is idle.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_threshold(logic [DIST_W-1:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        dist_limit = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_atom make_atom(int x, int y, int z, int occ);
        t_atom a;
        a.x   = COORD_W'(x);
        a.y   = COORD_W'(y);
        a.z   = COORD_W'(z);
        a.occ = OCC_W'(occ);
        return a;
    endfunction

    function automatic t_atom random_atom();
        return make_atom($urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic t_atom near_atom(t_atom c, int spread);
        t_atom a;
        a.x   = c.x + COORD_W'(int'($urandom_range(2 * spread)) - spread);
        a.y   = c.y + COORD_W'(int'($urandom_range(2 * spread)) - spread);
        a.z   = c.z + COORD_W'(int'($urandom_range(2 * spread)) - spread);
        a.occ = ($urandom_range(3) == 0) ? c.occ : OCC_W'($urandom);
        return a;
    endfunction

    function automatic logic [DIST_W-1:0] pick_threshold();
        case ($urandom_range(7))
            0:       return '0;
            1:       return DIST_MAX;
            2:       return DIST_W'({$urandom, $urandom});
            default: return DIST_W'($urandom_range(1 << 23));
        endcase
    endfunction

    task automatic test_single_atom();
        send_atom(make_atom(C_MAX, C_MIN, 0, 16'hFFFF), 1'b1);
        set_threshold(DIST_MAX);
        send_atom(make_atom(0, 0, 0, 0), 1'b1);
    endtask

    task automatic test_coordinate_extremes();
        set_threshold(DIST_MAX);
        send_atom(make_atom(C_MIN, C_MIN, C_MIN, 0), 1'b0);
        send_atom(make_atom(C_MAX, C_MAX, C_MAX, 16'hFFFF), 1'b0);
        send_atom(make_atom(C_MIN, C_MAX, C_MIN, 16'hFFFF), 1'b0);
        send_atom(make_atom(C_MAX, C_MIN, C_MAX, 0), 1'b1);
    endtask

    task automatic test_distance_boundary();
        set_threshold(DIST_W'(25));
        send_atom(make_atom(0, 0, 0, 100), 1'b0);
        send_atom(make_atom(3, -4, 0, 200), 1'b1);
        set_threshold(DIST_W'(26));
        send_atom(make_atom(0, 0, 0, 100), 1'b0);
        send_atom(make_atom(3, -4, 0, 200), 1'b1);
    endtask

    task automatic test_occupancy_ties();
        set_threshold(DIST_W'(1 << 16));
        send_atom(make_atom(0, 0, 0, 16'h4000), 1'b0);
        send_atom(make_atom(128, 0, 0, 16'h8000), 1'b0);
        send_atom(make_atom(0, -128, 0, 16'h8000), 1'b0);
        send_atom(make_atom(0, 0, 128, 16'h8000), 1'b0);
        send_atom(make_atom(10000, 0, 0, 16'h0001), 1'b1);
    endtask

    task automatic run_random_sets(int atom_budget, bit full_first);
        int    sent;
        int    n;
        int    spread;
        t_atom center;
        t_atom a;
        logic  is_last;
        sent = 0;
        while (sent < atom_budget) begin
            if ($urandom_range(3) == 0) set_threshold(pick_threshold());
            if (full_first && sent == 0) n = MAX_ATOMS;
            else n = ($urandom_range(39) == 0) ? MAX_ATOMS : $urandom_range(1, 12);
            center = random_atom();
            spread = 1 << $urandom_range(4, 10);
            for (int k = 0; k < n; k++) begin
                a = ($urandom_range(7) == 0) ? random_atom() : near_atom(center, spread);
                is_last = (k == n - 1) && (n < MAX_ATOMS || $urandom_range(1) == 1);
                send_atom(a, is_last);
            end
            sent += n;
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        set_threshold(DIST_W'(1 << 18));
        run_random_sets(80, 1'b1);
        sender_idle_pct = 60;
        run_random_sets(80, 1'b0);
        sender_idle_pct = 0;
        sink_stall_pct  = 60;
        run_random_sets(80, 1'b0);
        sender_idle_pct = 23;
        sink_stall_pct  = 23;
        run_random_sets(80, 1'b0);
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        m_axis_tready   = 1'b1;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        dist_limit      = '0;
        set_size        = 0;
        error_count     = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_atom();
        test_coordinate_extremes();
        test_distance_boundary();
        test_occupancy_ties();
        test_random_traffic();

        drain_results();
        repeat (100) @(negedge i_clk);
        if (error_count == 0) begin
            $display("near_duplicate_point_removal_test: done, clean");
        end else begin
            $display("near_duplicate_point_removal_test: done, errors");
        end
        $finish;
    end

endmodule
